### rtl/multi_slot_interval_timer_unit_macros.svh
`ifndef MULTI_SLOT_INTERVAL_TIMER_UNIT_MACROS_SVH
`define MULTI_SLOT_INTERVAL_TIMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define MSIT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define MSIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/msit_pkg.sv
`timescale 1ns / 1ps

package msit_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int OP_W       = 3;
  localparam int IDX_W      = 3;
  localparam int PERIOD_W   = 31;
  localparam int LIMIT_W    = 16;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int MASK_W     = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_SET     = 3'd1,
    OP_DELETE  = 3'd2,
    OP_RESTART = 3'd3,
    OP_ENABLE  = 3'd4,
    OP_DISABLE = 3'd5,
    OP_TOGGLE  = 3'd6,
    OP_QUERY   = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADSLOT = 2'd2
  } status_t;

  // Outcome of evaluating one slot on a tick
  typedef struct packed {
    logic                due;
    logic                fires;
    logic                last_run;
    logic [TIME_W-1:0]   base_next;
    logic [LIMIT_W-1:0]  count_next;
  } slot_eval_t;

endpackage

### rtl/msit_slot_unit.sv
`timescale 1ns / 1ps

// Shared slot evaluator: elapsed-time compare, base advance, run count
module msit_slot_unit (
  input  logic [msit_pkg::TIME_W-1:0]   now,
  input  logic [msit_pkg::TIME_W-1:0]   base,
  input  logic [msit_pkg::PERIOD_W-1:0] period,
  input  logic                          used,
  input  logic                          enabled,
  input  logic [msit_pkg::LIMIT_W-1:0]  run_count,
  input  logic [msit_pkg::LIMIT_W-1:0]  run_limit,
  output msit_pkg::slot_eval_t          ev
);
  import msit_pkg::*;

  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  period_ext;
  logic               limited;
  logic [LIMIT_W-1:0] count_inc;

  assign period_ext = {1'b0, period};
  // wrapping elapsed time since the base
  assign elapsed    = now - base;
  assign limited    = (run_limit != '0);
  assign count_inc  = run_count + LIMIT_W'(1);

  always_comb begin
    ev            = '0;
    ev.due        = used && (elapsed >= period_ext);
    ev.base_next  = base + period_ext;
    ev.fires      = ev.due && enabled && (!limited || (run_count < run_limit));
    ev.count_next = (ev.fires && limited) ? count_inc : run_count;
    ev.last_run   = ev.fires && limited && (count_inc >= run_limit);
  end

endmodule

### rtl/multi_slot_interval_timer_unit.sv
`timescale 1ns / 1ps
// Bank of NUM_SLOTS interval timers. Raise start with an operation, a slot
// index, a period, a run limit and the current time; the beat is taken on
// the edge where busy is low. A tick or a set walks the slots one per cycle
// through a single shared evaluation unit: a tick visits every slot, a set
// stops at the first free slot, which it claims (or visits every slot when
// the bank is full), and every other operation passes the command state.
// The result is shown for exactly one cycle with done high and cannot be
// held off, so capture it on that edge; busy is already low then and a new
// start may be given in the same cycle.
`include "multi_slot_interval_timer_unit_macros.svh"

module multi_slot_interval_timer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [msit_pkg::OP_W-1:0]     operation,
  input  logic [msit_pkg::IDX_W-1:0]    slot_index,
  input  logic [msit_pkg::PERIOD_W-1:0] period,
  input  logic [msit_pkg::LIMIT_W-1:0]  run_limit_in,
  input  logic [msit_pkg::TIME_W-1:0]   now,
  output logic                          done,
  output logic [msit_pkg::STATUS_W-1:0] status,
  output logic [msit_pkg::IDX_W-1:0]    slot_out,
  output logic                          enabled_flag,
  output logic [msit_pkg::MASK_W-1:0]   fire_mask,
  output logic [msit_pkg::MASK_W-1:0]   freed_mask
);
  import msit_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_CMD  = 3'b100
  } state_t;

  state_t state;

  // slot store
  logic [NUM_SLOTS-1:0] used;
  logic [NUM_SLOTS-1:0] enabled;
  logic [PERIOD_W-1:0]  period_mem [NUM_SLOTS];
  logic [LIMIT_W-1:0]   count_mem  [NUM_SLOTS];
  logic [LIMIT_W-1:0]   limit_mem  [NUM_SLOTS];
  logic [TIME_W-1:0]    base_mem   [NUM_SLOTS];

  // latched command beat
  logic [OP_W-1:0]      op_q;
  logic [IDX_W-1:0]     idx_q;
  logic [PERIOD_W-1:0]  period_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [TIME_W-1:0]    now_q;

  logic [SLOT_W-1:0]    cnt;
  logic [MASK_W-1:0]    fire_acc, fire_acc_next;
  logic [MASK_W-1:0]    freed_acc, freed_acc_next;
  logic [MASK_W-1:0]    cnt_bit;

  slot_eval_t           ev;
  logic                 accept, in_walk, in_cmd, is_tick;
  logic                 last, claim, walk_end, tick_upd;
  logic [SLOT_W-1:0]    idx_s;
  logic                 idx_ok, en_after;

  assign busy    = (state != S_IDLE);
  assign accept  = start && (state == S_IDLE);
  assign in_walk = (state == S_WALK);
  assign in_cmd  = (state == S_CMD);
  assign is_tick = (op_q == OP_TICK);

  // shared evaluator on the slot under the walk counter
  msit_slot_unit u_slot (
    .now       (now_q),
    .base      (base_mem[cnt]),
    .period    (period_mem[cnt]),
    .used      (used[cnt]),
    .enabled   (enabled[cnt]),
    .run_count (count_mem[cnt]),
    .run_limit (limit_mem[cnt]),
    .ev        (ev)
  );

  // walk control
  assign last     = (cnt == SLOT_W'(NUM_SLOTS - 1));
  assign claim    = in_walk && !is_tick && !used[cnt];
  assign walk_end = in_walk && (last || claim);
  assign tick_upd = in_walk && is_tick && ev.due;

  // mask accumulation; slots above the mask width shift out
  assign cnt_bit        = MASK_W'(1) << cnt;
  assign fire_acc_next  = fire_acc  | ((is_tick && ev.fires)    ? cnt_bit : '0);
  assign freed_acc_next = freed_acc | ((is_tick && ev.last_run) ? cnt_bit : '0);

  // addressed-slot check and resulting enable state
  assign idx_s  = SLOT_W'(idx_q);
  assign idx_ok = ({{(32-IDX_W){1'b0}}, idx_q} < 32'(NUM_SLOTS)) && used[idx_s];

  always_comb begin
    case (op_q)
      OP_DELETE:  en_after = 1'b0;
      OP_ENABLE:  en_after = 1'b1;
      OP_DISABLE: en_after = 1'b0;
      OP_TOGGLE:  en_after = !enabled[idx_s];
      default:    en_after = enabled[idx_s];
    endcase
  end

  // sequencer and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      cnt     <= '0;
      used    <= '0;
      enabled <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            if (operation == OP_TICK || operation == OP_SET) state <= S_WALK;
            else state <= S_CMD;
          end
        end
        S_WALK: begin
          cnt <= cnt + SLOT_W'(1);
          if (walk_end) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_CMD: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase

      if (claim) begin
        used[cnt]    <= 1'b1;
        enabled[cnt] <= 1'b1;
      end
      if (in_walk && is_tick && ev.last_run) begin
        used[cnt]    <= 1'b0;
        enabled[cnt] <= 1'b0;
      end
      if (in_cmd && idx_ok) begin
        enabled[idx_s] <= en_after;
        if (op_q == OP_DELETE) used[idx_s] <= 1'b0;
      end
    end
  end

  // datapath: beat capture, slot fields, result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= operation;
      idx_q     <= slot_index;
      period_q  <= period;
      limit_q   <= run_limit_in;
      now_q     <= now;
      fire_acc  <= '0;
      freed_acc <= '0;
    end
    if (in_walk) begin
      fire_acc  <= fire_acc_next;
      freed_acc <= freed_acc_next;
    end

    if (tick_upd) begin
      base_mem[cnt]  <= ev.base_next;
      count_mem[cnt] <= ev.count_next;
    end
    if (claim) begin
      period_mem[cnt] <= period_q;
      limit_mem[cnt]  <= limit_q;
      count_mem[cnt]  <= '0;
      base_mem[cnt]   <= now_q;
    end
    if (in_cmd && idx_ok && op_q == OP_RESTART) base_mem[idx_s] <= now_q;

    if (walk_end) begin
      fire_mask    <= '0;
      freed_mask   <= '0;
      status       <= ST_OK;
      slot_out     <= '0;
      enabled_flag <= 1'b0;
      if (is_tick) begin
        fire_mask  <= fire_acc_next;
        freed_mask <= freed_acc_next;
      end else if (claim) begin
        slot_out     <= IDX_W'(cnt);
        enabled_flag <= 1'b1;
      end else begin
        status <= ST_FULL;
      end
    end
    if (in_cmd) begin
      fire_mask    <= '0;
      freed_mask   <= '0;
      slot_out     <= idx_q;
      status       <= idx_ok ? ST_OK : ST_BADSLOT;
      enabled_flag <= idx_ok && en_after;
    end
  end

  // checks
  `MSIT_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `MSIT_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")
  `MSIT_ASSERT_NOW(a_freed_fired, clk, rst, done, (freed_mask & ~fire_mask) == '0,
                   "slot freed without a last run")
  `MSIT_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted beat did not raise busy")

endmodule

### tb/tb_multi_slot_interval_timer_unit.sv
`timescale 1ns / 1ps

module tb_multi_slot_interval_timer_unit;
  import msit_pkg::*;

  // One command beat and one result beat
  typedef struct {
    op_t                 op;
    logic [IDX_W-1:0]    idx;
    logic [PERIOD_W-1:0] per;
    logic [LIMIT_W-1:0]  lim;
    logic [TIME_W-1:0]   tnow;
  } timer_cmd_t;

  typedef struct {
    status_t             stat;
    logic [IDX_W-1:0]    slot;
    logic                en;
    logic [MASK_W-1:0]   fire;
    logic [MASK_W-1:0]   freed;
  } timer_res_t;

  // Directed row: command plus an optional hand-written result
  typedef struct {
    timer_cmd_t cmd;
    bit         typed;
    timer_res_t res;
  } cmd_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     operation;
  logic [IDX_W-1:0]    slot_index;
  logic [PERIOD_W-1:0] period;
  logic [LIMIT_W-1:0]  run_limit_in;
  logic [TIME_W-1:0]   now;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    slot_out;
  logic                enabled_flag;
  logic [MASK_W-1:0]   fire_mask;
  logic [MASK_W-1:0]   freed_mask;

  // Shadow copy of the timer bank
  bit                  bank_used [NUM_SLOTS];
  bit                  bank_en   [NUM_SLOTS];
  logic [PERIOD_W-1:0] bank_per  [NUM_SLOTS];
  logic [LIMIT_W-1:0]  bank_cnt  [NUM_SLOTS];
  logic [LIMIT_W-1:0]  bank_lim  [NUM_SLOTS];
  logic [TIME_W-1:0]   bank_base [NUM_SLOTS];

  timer_res_t          pending_results[$];
  cmd_row_t            directed_rows[$];
  int                  mismatches = 0;
  int                  idle_pct   = 0;
  logic [TIME_W-1:0]   clock_now  = '0;

  multi_slot_interval_timer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .slot_index   (slot_index),
    .period       (period),
    .run_limit_in (run_limit_in),
    .now          (now),
    .done         (done),
    .status       (status),
    .slot_out     (slot_out),
    .enabled_flag (enabled_flag),
    .fire_mask    (fire_mask),
    .freed_mask   (freed_mask)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5ms;
    $display("tb_multi_slot_interval_timer_unit: FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  function automatic void clear_slot(input int s);
    bank_used[s] = 1'b0;
    bank_en[s]   = 1'b0;
    bank_per[s]  = '0;
    bank_cnt[s]  = '0;
    bank_lim[s]  = '0;
  endfunction

  // Apply one command to the shadow bank and return its result
  function automatic timer_res_t step_timer_bank(input timer_cmd_t c);
    timer_res_t        r;
    logic [TIME_W-1:0] elapsed;
    bit                fires;
    bit                last_run;
    int                s;
    r = '{ST_OK, '0, 1'b0, '0, '0};
    case (c.op)
      OP_TICK: begin
        for (s = 0; s < NUM_SLOTS; s++) begin
          if (!bank_used[s]) continue;
          elapsed = c.tnow - bank_base[s];
          if (elapsed < {1'b0, bank_per[s]}) continue;
          bank_base[s] = bank_base[s] + {1'b0, bank_per[s]};
          fires    = 1'b0;
          last_run = 1'b0;
          if (bank_en[s]) begin
            if (bank_lim[s] == '0) begin
              fires = 1'b1;
            end else if (bank_cnt[s] < bank_lim[s]) begin
              fires = 1'b1;
              bank_cnt[s] = bank_cnt[s] + LIMIT_W'(1);
              last_run = (bank_cnt[s] >= bank_lim[s]);
            end
          end
          if (fires && s < MASK_W) r.fire[s] = 1'b1;
          if (last_run) begin
            if (s < MASK_W) r.freed[s] = 1'b1;
            clear_slot(s);
          end
        end
      end
      OP_SET: begin
        for (s = 0; s < NUM_SLOTS; s++)
          if (!bank_used[s]) break;
        if (s >= NUM_SLOTS) begin
          r.stat = ST_FULL;
        end else begin
          bank_used[s] = 1'b1;
          bank_en[s]   = 1'b1;
          bank_per[s]  = c.per;
          bank_lim[s]  = c.lim;
          bank_cnt[s]  = '0;
          bank_base[s] = c.tnow;
          r.slot = s[IDX_W-1:0];
          r.en   = 1'b1;
        end
      end
      default: begin
        r.slot = c.idx;
        if (c.idx >= NUM_SLOTS || !bank_used[c.idx]) begin
          r.stat = ST_BADSLOT;
        end else begin
          case (c.op)
            OP_DELETE:  clear_slot(c.idx);
            OP_RESTART: bank_base[c.idx] = c.tnow;
            OP_ENABLE:  bank_en[c.idx] = 1'b1;
            OP_DISABLE: bank_en[c.idx] = 1'b0;
            OP_TOGGLE:  bank_en[c.idx] = !bank_en[c.idx];
            default: ;
          endcase
          r.en = bank_en[c.idx];
        end
      end
    endcase
    return r;
  endfunction

  // Present one beat from a falling edge and hold it until taken
  task automatic issue(input timer_cmd_t c, input bit typed, input timer_res_t typed_res);
    timer_res_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    operation    = c.op;
    slot_index   = c.idx;
    period       = c.per;
    run_limit_in = c.lim;
    now          = c.tnow;
    start        = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = step_timer_bank(c);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic add_row(input op_t op, input int idx, input logic [PERIOD_W-1:0] per,
                         input logic [LIMIT_W-1:0] lim, input logic [TIME_W-1:0] tnow,
                         input bit typed = 1'b0, input status_t stat = ST_OK,
                         input int slot = 0, input bit en = 1'b0);
    cmd_row_t row;
    row.cmd   = '{op, idx[IDX_W-1:0], per, lim, tnow};
    row.typed = typed;
    row.res   = '{stat, slot[IDX_W-1:0], en, '0, '0};
    directed_rows.push_back(row);
  endtask

  // Random command: mostly a plausible timer workload, some noise
  task automatic random_cmd(output timer_cmd_t c);
    int pick;
    int used_list[$];
    pick = $urandom_range(0, 99);
    if (pick < 35)      c.op = OP_TICK;
    else if (pick < 55) c.op = OP_SET;
    else if (pick < 64) c.op = OP_DELETE;
    else if (pick < 71) c.op = OP_RESTART;
    else if (pick < 78) c.op = OP_ENABLE;
    else if (pick < 85) c.op = OP_DISABLE;
    else if (pick < 92) c.op = OP_TOGGLE;
    else                c.op = OP_QUERY;

    // time mostly creeps forward, with the odd jump anywhere
    if ($urandom_range(0, 99) < 3) clock_now = $urandom;
    else                           clock_now = clock_now + $urandom_range(0, 20);
    c.tnow = clock_now;

    for (int s = 0; s < NUM_SLOTS; s++)
      if (bank_used[s]) used_list.push_back(s);
    if (used_list.size() != 0 && $urandom_range(0, 99) < 80)
      c.idx = IDX_W'(used_list[$urandom_range(0, used_list.size() - 1)]);
    else
      c.idx = IDX_W'($urandom_range(0, 7));

    pick = $urandom_range(0, 99);
    if (pick < 70)      c.per = PERIOD_W'($urandom_range(0, 40));
    else if (pick < 90) c.per = PERIOD_W'($urandom_range(0, 1000));
    else                c.per = PERIOD_W'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 40)      c.lim = '0;
    else if (pick < 85) c.lim = LIMIT_W'($urandom_range(1, 5));
    else                c.lim = LIMIT_W'($urandom);
  endtask

  // Result checker: one beat per done strobe
  always @(posedge clk) begin
    timer_res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing outstanding", 32'({fire_mask, freed_mask}), '0);
      end else begin
        want = pending_results.pop_front();
        if (status != want.stat)
          flag_mismatch("status", 32'(status), 32'(want.stat));
        if (slot_out != want.slot)
          flag_mismatch("slot_out", 32'(slot_out), 32'(want.slot));
        if (enabled_flag != want.en)
          flag_mismatch("enabled_flag", 32'(enabled_flag), 32'(want.en));
        if (fire_mask != want.fire)
          flag_mismatch("fire_mask", 32'(fire_mask), 32'(want.fire));
        if (freed_mask != want.freed)
          flag_mismatch("freed_mask", 32'(freed_mask), 32'(want.freed));
      end
    end
  end

  initial begin
    timer_cmd_t cmd;
    timer_res_t no_res;
    int         idle_by_phase[3];
    idle_by_phase = '{29, 88, 0};
    no_res       = '{ST_OK, '0, 1'b0, '0, '0};
    rst          = 1'b1;
    start        = 1'b0;
    operation    = OP_TICK;
    slot_index   = '0;
    period       = '0;
    run_limit_in = '0;
    now          = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      clear_slot(s);
      bank_base[s] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty bank, extremes, every operation, full bank
    add_row(OP_TICK,    0, '0, '0, '0, 1'b1, ST_OK, 0, 1'b0);
    add_row(OP_QUERY,   7, '0, '0, '0, 1'b1, ST_BADSLOT, 7, 1'b0);
    add_row(OP_DELETE,  3, '0, '0, '0, 1'b1, ST_BADSLOT, 3, 1'b0);
    add_row(OP_SET,     0, '0, 16'd1, 32'd5, 1'b1, ST_OK, 0, 1'b1);
    // zero period, single run: fires and frees on the first tick
    add_row(OP_TICK,    0, '0, '0, 32'd5);
    add_row(OP_SET,     0, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 0, 1'b1);
    add_row(OP_SET,     0, 31'd10, '0, 32'hFFFF_FFF8);
    // elapsed time measured across the wrap of now
    add_row(OP_TICK,    0, '0, '0, 32'd2);
    add_row(OP_DISABLE, 1, '0, '0, 32'd3);
    add_row(OP_TICK,    0, '0, '0, 32'd12);
    add_row(OP_TOGGLE,  1, '0, '0, 32'd13);
    add_row(OP_TOGGLE,  1, '0, '0, 32'd14);
    add_row(OP_ENABLE,  1, '0, '0, 32'd15);
    add_row(OP_RESTART, 1, '0, '0, 32'd100);
    add_row(OP_QUERY,   0, '0, '0, 32'd101);
    add_row(OP_SET,     0, '0, 16'd2, 32'd102);
    add_row(OP_SET,     0, 31'd1, '0, 32'd103);
    add_row(OP_SET,     0, 31'd3, 16'd3, 32'd104);
    add_row(OP_SET,     0, 31'd7, 16'd1, 32'd105);
    add_row(OP_SET,     0, 31'h4000_0000, '0, 32'd106);
    add_row(OP_SET,     0, 31'd5, 16'h8000, 32'd107);
    // bank full now
    add_row(OP_SET,     0, 31'd9, 16'd4, 32'd108, 1'b1, ST_FULL, 0, 1'b0);
    add_row(OP_TICK,    0, '0, '0, 32'h8000_0000);
    add_row(OP_DELETE,  7, '0, '0, 32'h8000_0001);
    add_row(OP_DELETE,  0, '0, '0, 32'h8000_0002);

    idle_pct = 10;
    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
    clock_now = 32'h8000_0010;

    // Random: three idling profiles, results drained before each
    for (int ph = 0; ph < 3; ph++) begin
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
      idle_pct = idle_by_phase[ph];
      for (int n = 0; n < 442; n++) begin
        if (ph == 0 && n == 200) begin
          // hold off until every outstanding result is back
          start = 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
        random_cmd(cmd);
        issue(cmd, 1'b0, no_res);
      end
    end
    start = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_multi_slot_interval_timer_unit: PASS");
    end else begin
      $display("tb_multi_slot_interval_timer_unit: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/msit_pkg.sv
rtl/msit_slot_unit.sv
rtl/multi_slot_interval_timer_unit.sv
tb/tb_multi_slot_interval_timer_unit.sv
